// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2c_mts_pkg.sv =====
// Shared codes for the I2C master transfer sequencer.
`default_nettype none

package i2c_mts_pkg;

	// Input item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_EVENT = 2'd2;
	// Unused kind: no action, the result reports the current state
	localparam logic [1:0] KIND_NONE  = 2'd3;

	// Transfer phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TX   = 2'd1;
	localparam logic [1:0] PH_RX   = 2'd2;
	localparam logic [1:0] PH_WAIT = 2'd3;

	// Reported transfer status
	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_BUSY  = 2'd1;
	localparam logic [1:0] ST_ERROR = 2'd2;

	typedef struct packed {
		logic       load_tx;
		logic [7:0] tx_data;
		logic       send_stop;
		logic       send_start;
		logic       read_mode;
		logic       store_rx;
		logic [7:0] rx_data;
		logic [7:0] byte_index;
		logic [1:0] transfer_status;
		logic [7:0] bytes_left;
		logic [3:0] fault_bits;
		logic       done_res;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_master_transfer_sequencer_unit.sv =====
// I2C master transfer sequencer: commands and controller events in, actions out.
//
// Input channel (in_valid / in_stall): one transaction is a start-write command,
// a start-read command or a controller status event (kind selects). Output
// channel (out_valid / out_stall): exactly one result transaction per input
// transaction, in order, carrying controller actions, buffer index, status,
// remaining byte count and the fault bits saved at the last abort.
// The result is registered and appears on the outputs in the cycle after the
// input is accepted. Throughput: one transaction per cycle while no result is
// held stalled; the transfer state and the result register both update at the
// accepting edge, so the next item sees the updated state at once.
// Stall: the result register holds its transaction while out_stall is high;
// in_stall rises only while a result is held and stalled, and a new item is
// accepted in the same cycle that the held result is taken.
// Reset (arst_n low): phase idle, count and position zero, status ready, saved
// fault bits zero, no result pending.
`default_nettype none

module i2c_master_transfer_sequencer_unit
	import i2c_mts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] kind,
	input  wire logic [7:0] length,
	input  wire logic [7:0] tx_byte,
	input  wire logic       ev_txrdy,
	input  wire logic       ev_rxrdy,
	input  wire logic       ev_txcomp,
	input  wire logic       ev_nack,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            load_tx,
	output logic [7:0]      tx_data,
	output logic            send_stop,
	output logic            send_start,
	output logic            read_mode,
	output logic            store_rx,
	output logic [7:0]      rx_data,
	output logic [7:0]      byte_index,
	output logic [1:0]      transfer_status,
	output logic [7:0]      bytes_left,
	output logic [3:0]      fault_bits,
	output logic            done_res
);

	logic [1:0] phase_q;
	logic [7:0] remaining_q;
	logic [7:0] position_q;
	logic [1:0] status_q;
	logic [3:0] fault_q;

	logic [1:0] phase_d;
	logic [7:0] remaining_d;
	logic [7:0] position_d;
	logic [1:0] status_d;
	logic [3:0] fault_d;

	logic [7:0] rem_dec;
	logic       in_fire;
	logic       out_valid_q;
	result_t    res_d;
	result_t    res_q;

	assign in_stall = out_valid_q & out_stall;
	assign in_fire  = in_valid & ~in_stall;
	assign rem_dec  = remaining_q - 8'd1;

	// Decode the item against the current phase
	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		position_d  = position_q;
		status_d    = status_q;
		fault_d     = fault_q;
		res_d       = '0;
		res_d.byte_index = 8'd0;

		unique case (kind)
			KIND_WRITE: begin
				status_d    = ST_BUSY;
				phase_d     = PH_TX;
				res_d.load_tx = 1'b1;
				res_d.tx_data = tx_byte;
				position_d  = 8'd1;
				remaining_d = (length == 8'd0) ? 8'd0 : length - 8'd1;
			end
			KIND_READ: begin
				status_d    = ST_BUSY;
				phase_d     = PH_RX;
				position_d  = 8'd0;
				remaining_d = (length < 8'd2) ? 8'd2 : length;
				res_d.send_start = 1'b1;
			end
			KIND_EVENT: begin
				if (phase_q != PH_IDLE) begin
					if (ev_nack) begin
						res_d.send_stop = 1'b1;
						phase_d  = PH_IDLE;
						fault_d  = {ev_nack, ev_txcomp, ev_rxrdy, ev_txrdy};
						status_d = ST_ERROR;
						res_d.done_res = 1'b1;
					end else if (phase_q == PH_RX && ev_rxrdy) begin
						res_d.store_rx = 1'b1;
						res_d.rx_data  = rx_byte;
						position_d  = position_q + 8'd1;
						remaining_d = rem_dec;
						if (rem_dec == 8'd1) begin
							res_d.send_stop = 1'b1;
						end
						if (rem_dec == 8'd0) begin
							phase_d  = PH_IDLE;
							status_d = ST_READY;
							res_d.done_res = 1'b1;
						end
					end else if (phase_q == PH_TX && ev_txrdy) begin
						if (remaining_q != 8'd0) begin
							res_d.load_tx = 1'b1;
							res_d.tx_data = tx_byte;
							position_d  = position_q + 8'd1;
							remaining_d = rem_dec;
						end else begin
							phase_d = PH_WAIT;
						end
					end else if (phase_q == PH_WAIT && ev_txcomp) begin
						phase_d  = PH_IDLE;
						status_d = ST_READY;
						res_d.done_res = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		res_d.read_mode       = (phase_q == PH_RX) || (phase_d == PH_RX);
		res_d.byte_index      = res_d.store_rx ? position_q : position_d;
		res_d.transfer_status = status_d;
		res_d.bytes_left      = remaining_d;
		res_d.fault_bits      = fault_d;
	end

	// Advance transfer state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= 8'd0;
			position_q  <= 8'd0;
			status_q    <= ST_READY;
			fault_q     <= 4'd0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			position_q  <= position_d;
			status_q    <= status_d;
			fault_q     <= fault_d;
		end
	end

	// Hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign load_tx         = res_q.load_tx;
	assign tx_data         = res_q.tx_data;
	assign send_stop       = res_q.send_stop;
	assign send_start      = res_q.send_start;
	assign read_mode       = res_q.read_mode;
	assign store_rx        = res_q.store_rx;
	assign rx_data         = res_q.rx_data;
	assign byte_index      = res_q.byte_index;
	assign transfer_status = res_q.transfer_status;
	assign bytes_left      = res_q.bytes_left;
	assign fault_bits      = res_q.fault_bits;
	assign done_res        = res_q.done_res;

endmodule

`default_nettype wire

// ===== rtl/core/i2c_mts_checker.sv =====
// Port-level checker for the I2C master transfer sequencer, with its bind.
`default_nettype none
`include "assert_macros.svh"

module i2c_mts_checker
	import i2c_mts_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] kind,
	input wire logic [7:0] length,
	input wire logic [7:0] tx_byte,
	input wire logic       ev_txrdy,
	input wire logic       ev_rxrdy,
	input wire logic       ev_txcomp,
	input wire logic       ev_nack,
	input wire logic [7:0] rx_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       load_tx,
	input wire logic [7:0] tx_data,
	input wire logic       send_stop,
	input wire logic       send_start,
	input wire logic       read_mode,
	input wire logic       store_rx,
	input wire logic [7:0] rx_data,
	input wire logic [7:0] byte_index,
	input wire logic [1:0] transfer_status,
	input wire logic [7:0] bytes_left,
	input wire logic [3:0] fault_bits,
	input wire logic       done_res
);

	// A finished transfer never reports busy
	`CHK_IMPLY(a_done_not_busy, clk, arst_n, out_valid && done_res, transfer_status != ST_BUSY, "done with busy status")

	// A read start always reports a busy read
	`CHK_IMPLY(a_start_is_read, clk, arst_n, out_valid && send_start, read_mode && transfer_status == ST_BUSY && !done_res, "start without busy read")

	// An error result carries a saved nack bit
	`CHK_IMPLY(a_error_has_nack, clk, arst_n, out_valid && transfer_status == ST_ERROR, fault_bits[3], "error without saved nack")

	// A stalled result stays on the port
	`CHK_NEXT(a_hold_stalled, clk, arst_n, out_valid && out_stall, out_valid && $stable(bytes_left) && $stable(byte_index), "stalled result changed")

endmodule

bind i2c_master_transfer_sequencer_unit i2c_mts_checker u_i2c_mts_checker (.*);

`default_nettype wire
